// ===== sv/versioned_transactional_memory_assert.svh =====
// Assertion macros for the versioned transactional memory.
`ifndef VERSIONED_TRANSACTIONAL_MEMORY_ASSERT_SVH
`define VERSIONED_TRANSACTIONAL_MEMORY_ASSERT_SVH
`ifndef ASSERT_OFF
`define VTM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define VTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define VTM_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define VTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/vtm_pkg.sv =====
// Shared types and constants of the versioned transactional memory.
package vtm_pkg;
    localparam int CELLS_DEF    = 1024;
    localparam int CONTEXTS_DEF = 4;
    localparam int DATA_W       = 64;

    typedef enum logic [1:0] {
        OP_START, OP_READ, OP_WRITE, OP_COMMIT
    } t_op;

    typedef enum logic [1:0] {
        STATUS_OK, STATUS_CONFLICT, STATUS_ABORT
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_ACCESS, S_START, S_CHECK, S_CHECK_TAIL, S_APPLY, S_APPLY_TAIL
    } t_state;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] version;
    } t_cell;

    typedef struct packed {
        logic              rmark;
        logic              wmark;
        logic [DATA_W-1:0] buffer;
    } t_slot;
endpackage

// ===== sv/versioned_transactional_memory.sv =====
// Top level: transaction sequencer around the cell and context stores.
//
//  channel   direction  handshake             payload
//  request   in         start high, busy low  i_operation, i_context_req, i_cell_index,
//                                              i_write_value
//  result    out        o_valid, one cycle     o_read_value, o_status
//
// Read and write do one store read, then the update and result.
// Start and commit both walk the context's slots in the context store one
// slot per cycle.
// After reset a clearing pass over all CELLS * CONTEXTS slots runs with busy high.
// The result cannot be stalled; a new request is taken while it is shown.
module versioned_transactional_memory #(
    parameter int CELLS    = vtm_pkg::CELLS_DEF,
    parameter int CONTEXTS = vtm_pkg::CONTEXTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_operation,
    input  logic [1:0]  i_context_req,
    input  logic [9:0]  i_cell_index,
    input  logic [63:0] i_write_value,
    output logic        o_valid,
    output logic [63:0] o_read_value,
    output logic [1:0]  o_status
);
    localparam int CELL_W = $clog2(CELLS);
    localparam int CTX_W  = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
    localparam int SLOT_W = $clog2(CONTEXTS * CELLS);

    vtm_pkg::t_state r_state, n_state;
    logic [CELL_W-1:0] r_cnt, n_cnt, r_pend_cell, n_pend_cell;
    logic [CTX_W-1:0]  r_ctx, n_ctx;
    logic [SLOT_W-1:0] r_base, n_base, r_slot, n_slot;
    logic              r_pend, n_pend, r_ign, n_ign;
    vtm_pkg::t_op      r_op, n_op;
    logic [63:0]       r_wval, n_wval, r_clock, n_clock;
    logic [63:0]       r_start_ver [CONTEXTS];
    logic              r_valid, n_valid;
    logic [63:0]       r_rdata, n_rdata;
    vtm_pkg::t_status  r_status, n_status;

    logic [CELL_W-1:0] cm_addr;
    logic              cm_we;
    vtm_pkg::t_cell    cm_wd, cm_rd;
    logic [SLOT_W-1:0] xm_addr;
    logic              xm_we;
    vtm_pkg::t_slot    xm_wd, xm_rd;

    logic              take, ctx_ok, cell_ok, set_start, hit;
    logic [SLOT_W-1:0] in_base;
    logic [CTX_W-1:0]  in_ctx;

    vtm_cell_mem #(.DEPTH(CELLS), .AW(CELL_W)) u_cell_mem (
        .i_clk(i_clk), .i_addr(cm_addr), .i_we(cm_we), .i_wdata(cm_wd), .o_rdata(cm_rd)
    );

    vtm_ctx_mem #(.DEPTH(CONTEXTS * CELLS), .AW(SLOT_W)) u_ctx_mem (
        .i_clk(i_clk), .i_addr(xm_addr), .i_we(xm_we), .i_wdata(xm_wd), .o_rdata(xm_rd)
    );

    assign busy         = (r_state != vtm_pkg::S_IDLE);
    assign o_valid      = r_valid;
    assign o_read_value = r_rdata;
    assign o_status     = r_status;

    assign take    = start && !busy;
    assign ctx_ok  = 32'(i_context_req) < CONTEXTS;
    assign cell_ok = 32'(i_cell_index) < CELLS;
    assign in_ctx  = CTX_W'(i_context_req);
    assign in_base = SLOT_W'(in_ctx) * SLOT_W'(CELLS);
    assign hit     = r_pend && xm_rd.rmark && (cm_rd.version >= r_start_ver[r_ctx]);

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_pend_cell = r_pend_cell;
        n_ctx = r_ctx;
        n_base = r_base;
        n_slot = r_slot;
        n_pend = r_pend;
        n_ign = r_ign;
        n_op = r_op;
        n_wval = r_wval;
        n_clock = r_clock;
        n_valid = 1'b0;
        n_rdata = '0;
        n_status = vtm_pkg::STATUS_OK;
        set_start = 1'b0;
        cm_addr = r_cnt;
        cm_we = 1'b0;
        cm_wd = '0;
        xm_addr = r_base + SLOT_W'(r_cnt);
        xm_we = 1'b0;
        xm_wd = '0;
        case (r_state)
            vtm_pkg::S_CLEAR: begin
                cm_we = 1'b1;
                xm_we = 1'b1;
                if (r_cnt == CELL_W'(CELLS - 1)) begin
                    n_cnt = '0;
                    if (r_ctx == CTX_W'(CONTEXTS - 1)) begin
                        n_state = vtm_pkg::S_IDLE;
                        n_ctx = '0;
                        n_base = '0;
                    end else begin
                        n_ctx = r_ctx + 1'b1;
                        n_base = r_base + SLOT_W'(CELLS);
                    end
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            vtm_pkg::S_IDLE: begin
                cm_addr = CELL_W'(i_cell_index);
                xm_addr = in_base + SLOT_W'(CELL_W'(i_cell_index));
                if (take) begin
                    n_ctx = in_ctx;
                    n_base = in_base;
                    n_slot = xm_addr;
                    n_op = vtm_pkg::t_op'(i_operation);
                    n_wval = i_write_value;
                    n_cnt = '0;
                    n_pend = 1'b0;
                    n_ign = !ctx_ok || (!cell_ok && (i_operation == vtm_pkg::OP_READ ||
                                                     i_operation == vtm_pkg::OP_WRITE));
                    n_state = vtm_pkg::S_ACCESS;
                    if (ctx_ok && i_operation == vtm_pkg::OP_START) begin
                        set_start = 1'b1;
                        n_state = vtm_pkg::S_START;
                    end else if (ctx_ok && i_operation == vtm_pkg::OP_COMMIT) begin
                        n_state = vtm_pkg::S_CHECK;
                    end
                end
            end
            vtm_pkg::S_ACCESS: begin
                xm_addr = r_slot;
                n_valid = 1'b1;
                n_state = vtm_pkg::S_IDLE;
                if (!r_ign && r_op == vtm_pkg::OP_READ) begin
                    if (xm_rd.wmark) begin
                        n_rdata = xm_rd.buffer;
                    end else if (cm_rd.version >= r_start_ver[r_ctx]) begin
                        n_status = vtm_pkg::STATUS_CONFLICT;
                    end else begin
                        xm_we = 1'b1;
                        xm_wd = xm_rd;
                        xm_wd.rmark = 1'b1;
                        n_rdata = cm_rd.value;
                    end
                end else if (!r_ign && r_op == vtm_pkg::OP_WRITE) begin
                    xm_we = 1'b1;
                    xm_wd.rmark = xm_rd.rmark;
                    xm_wd.wmark = 1'b1;
                    xm_wd.buffer = r_wval;
                end
            end
            vtm_pkg::S_START: begin
                xm_we = 1'b1;
                if (r_cnt == CELL_W'(CELLS - 1)) begin
                    n_valid = 1'b1;
                    n_state = vtm_pkg::S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            vtm_pkg::S_CHECK, vtm_pkg::S_CHECK_TAIL: begin
                n_pend = 1'b1;
                n_pend_cell = r_cnt;
                if (hit) begin
                    n_valid = 1'b1;
                    n_status = vtm_pkg::STATUS_ABORT;
                    n_state = vtm_pkg::S_IDLE;
                end else if (r_state == vtm_pkg::S_CHECK_TAIL) begin
                    n_state = vtm_pkg::S_APPLY;
                    n_cnt = '0;
                    n_pend = 1'b0;
                end else if (r_cnt == CELL_W'(CELLS - 1)) begin
                    n_state = vtm_pkg::S_CHECK_TAIL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            vtm_pkg::S_APPLY, vtm_pkg::S_APPLY_TAIL: begin
                n_pend = 1'b1;
                n_pend_cell = r_cnt;
                if (r_pend && xm_rd.wmark) begin
                    cm_we = 1'b1;
                    cm_addr = r_pend_cell;
                    cm_wd.value = xm_rd.buffer;
                    cm_wd.version = r_clock;
                end
                if (r_state == vtm_pkg::S_APPLY_TAIL) begin
                    n_clock = r_clock + 64'd1;
                    n_valid = 1'b1;
                    n_pend = 1'b0;
                    n_state = vtm_pkg::S_IDLE;
                end else if (r_cnt == CELL_W'(CELLS - 1)) begin
                    n_state = vtm_pkg::S_APPLY_TAIL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                n_state = vtm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vtm_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_ctx   <= '0;
            r_base  <= '0;
            r_pend  <= 1'b0;
            r_clock <= 64'd1;
            r_valid <= 1'b0;
            for (int i = 0; i < CONTEXTS; i++) begin
                r_start_ver[i] <= '0;
            end
        end else begin
            r_cnt   <= n_cnt;
            r_ctx   <= n_ctx;
            r_base  <= n_base;
            r_pend  <= n_pend;
            r_clock <= n_clock;
            r_valid <= n_valid;
            if (set_start) begin
                r_start_ver[in_ctx] <= r_clock;
            end
        end
        r_pend_cell <= n_pend_cell;
        r_slot      <= n_slot;
        r_ign       <= n_ign;
        r_op        <= n_op;
        r_wval      <= n_wval;
        r_rdata     <= n_rdata;
        r_status    <= n_status;
    end

`include "versioned_transactional_memory_assert.svh"

    `VTM_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, take, busy)
    `VTM_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid)
    `VTM_ASSERT_SAME(a_result_idle, i_clk, i_rst_n, o_valid, !busy)
    `VTM_ASSERT_SAME(a_fail_zero, i_clk, i_rst_n,
        o_valid && o_status != vtm_pkg::STATUS_OK, o_read_value == 64'd0)
endmodule

// ===== sv/vtm_cell_mem.sv =====
// Shared cell store: value and commit version per cell, registered read.
module vtm_cell_mem #(
    parameter int DEPTH = vtm_pkg::CELLS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_addr,
    input  logic          i_we,
    input  vtm_pkg::t_cell i_wdata,
    output vtm_pkg::t_cell o_rdata
);
    vtm_pkg::t_cell mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end
endmodule

// ===== sv/vtm_ctx_mem.sv =====
// Per-context store: read mark, write mark and buffered write per slot.
module vtm_ctx_mem #(
    parameter int DEPTH = vtm_pkg::CELLS_DEF * vtm_pkg::CONTEXTS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_addr,
    input  logic          i_we,
    input  vtm_pkg::t_slot i_wdata,
    output vtm_pkg::t_slot o_rdata
);
    vtm_pkg::t_slot mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end
endmodule
